// ===== hw/rtl/rpn_pkg.sv =====
`timescale 1ns / 1ps
package rpn_pkg;

  localparam int DATA_W = 32;
  localparam int NUM_W  = 31;
  localparam int REQ_W  = 2;
  localparam int OP_W   = 2;
  localparam int ST_W   = 3;

  // token kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH    = 2'd0,
    REQ_OP      = 2'd1,
    REQ_END     = 2'd2,
    REQ_INVALID = 2'd3
  } req_e_t;

  // operators
  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FEW      = 3'd1,
    ST_INVALID  = 3'd2,
    ST_COUNT    = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_DIVZERO  = 3'd5
  } status_e_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_EMIT
  } state_e_t;

endpackage

// ===== hw/rtl/rpn_in_if.sv =====
`timescale 1ns / 1ps
interface rpn_in_if;
  logic                          valid;
  logic                          ready;
  logic [rpn_pkg::REQ_W-1:0]     req_type;
  logic [rpn_pkg::NUM_W-1:0]     number_value;
  logic [rpn_pkg::OP_W-1:0]      op_code;

  modport source (output valid, output req_type, output number_value, output op_code,
                  input ready);
  modport sink (input valid, input req_type, input number_value, input op_code,
                output ready);
endinterface

// ===== hw/rtl/rpn_out_if.sv =====
`timescale 1ns / 1ps
interface rpn_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rpn_pkg::DATA_W-1:0]  value;
  logic [rpn_pkg::ST_W-1:0]           status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

// ===== hw/rtl/rpn_stack_mem.sv =====
`timescale 1ns / 1ps
module rpn_stack_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [rpn_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [rpn_pkg::DATA_W-1:0] rd_data
);

  logic [rpn_pkg::DATA_W-1:0] mem [DEPTH];
  logic [rpn_pkg::DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/rpn_div.sv =====
`timescale 1ns / 1ps
module rpn_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rpn_pkg::DATA_W-1:0] dividend,
  input  logic [rpn_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [rpn_pkg::DATA_W-1:0] quotient
);

  localparam int DW = rpn_pkg::DATA_W;
  localparam int CW = $clog2(DW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic          neg_r, neg_nxt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;

  // one restoring step per cycle on the magnitudes
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    rem_sh   = {rem_r[DW-1:0], quo_r[DW-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend[DW-1] ? (DW'(0) - dividend) : dividend;
      dvs_nxt  = divisor[DW-1] ? (DW'(0) - divisor) : divisor;
      neg_nxt  = dividend[DW-1] ^ divisor[DW-1];
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // sign fix-up, most negative over minus one wraps by itself
  assign done     = done_r;
  assign quotient = neg_r ? (DW'(0) - quo_r) : quo_r;

endmodule

// ===== hw/rtl/rpn_stack_evaluator_top.sv =====
`timescale 1ns / 1ps
// push loads top_r; add, subtract and multiply read the stack memory, then apply the op
// divide reads the stack memory, then waits in S_DIV on the one-bit-per-cycle iterative divider
// a token that gives a result waits in S_EMIT while the output register is still held
// one token at a time; a push can be taken every cycle unless it overflows the stack
// reset: synchronous active-low rst_n clears the count, error flag, fsm and output valid;
// stack memory contents are not cleared
module rpn_stack_evaluator_top #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  rpn_in_if.sink            in_ch,
  rpn_out_if.source         out_ch
);

  localparam int DW = rpn_pkg::DATA_W;
  localparam int AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  rpn_pkg::state_e_t  state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               disc_r, disc_nxt;
  logic [DW-1:0]      top_r, top_nxt;
  rpn_pkg::op_e_t     op_r, op_nxt;
  logic [DW-1:0]      res_val_r, res_val_nxt;
  rpn_pkg::status_e_t res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DW-1:0]      out_val_r, out_val_nxt;
  rpn_pkg::status_e_t out_st_r, out_st_nxt;

  logic               accept;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [DW-1:0]      rd_data;
  logic [CW-1:0]      cnt_m1;
  logic [CW-1:0]      cnt_m2;
  logic [DW-1:0]      quotient;
  logic               div_start;
  logic               div_done;
  rpn_pkg::req_e_t    req;

  assign req         = rpn_pkg::req_e_t'(in_ch.req_type);
  assign in_ch.ready = (state_r == rpn_pkg::S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign cnt_m1      = count_r - CW'(1);
  assign cnt_m2      = count_r - CW'(2);

  rpn_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (top_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // top of stack lives in top_r, entries below it in the memory
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    disc_nxt      = disc_r;
    top_nxt       = top_r;
    op_nxt        = op_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_m1[AW-1:0];
    rd_en         = 1'b0;
    rd_addr       = cnt_m2[AW-1:0];
    div_start     = 1'b0;

    unique case (state_r)
      rpn_pkg::S_IDLE: begin
        if (accept) begin
          if (req == rpn_pkg::REQ_END) begin
            count_nxt = '0;
            disc_nxt  = 1'b0;
            if (!disc_r) begin
              state_nxt = rpn_pkg::S_EMIT;
              if (count_r == CW'(1)) begin
                res_val_nxt = top_r;
                res_st_nxt  = rpn_pkg::ST_OK;
              end else begin
                res_val_nxt = '0;
                res_st_nxt  = rpn_pkg::ST_COUNT;
              end
            end
          end else if (!disc_r) begin
            unique case (req)
              rpn_pkg::REQ_PUSH: begin
                if (count_r == CW'(STACK_DEPTH)) begin
                  disc_nxt    = 1'b1;
                  res_val_nxt = '0;
                  res_st_nxt  = rpn_pkg::ST_OVERFLOW;
                  state_nxt   = rpn_pkg::S_EMIT;
                end else begin
                  wr_en     = (count_r != '0);
                  top_nxt   = {1'b0, in_ch.number_value};
                  count_nxt = count_r + CW'(1);
                end
              end
              rpn_pkg::REQ_OP: begin
                if (count_r < CW'(2)) begin
                  disc_nxt    = 1'b1;
                  res_val_nxt = '0;
                  res_st_nxt  = rpn_pkg::ST_FEW;
                  state_nxt   = rpn_pkg::S_EMIT;
                end else if (rpn_pkg::op_e_t'(in_ch.op_code) == rpn_pkg::OP_DIV &&
                             top_r == '0) begin
                  disc_nxt    = 1'b1;
                  res_val_nxt = '0;
                  res_st_nxt  = rpn_pkg::ST_DIVZERO;
                  state_nxt   = rpn_pkg::S_EMIT;
                end else begin
                  rd_en     = 1'b1;
                  op_nxt    = rpn_pkg::op_e_t'(in_ch.op_code);
                  state_nxt = rpn_pkg::S_READ;
                end
              end
              default: begin
                disc_nxt    = 1'b1;
                res_val_nxt = '0;
                res_st_nxt  = rpn_pkg::ST_INVALID;
                state_nxt   = rpn_pkg::S_EMIT;
              end
            endcase
          end
        end
      end

      // left operand from memory, right operand in top_r
      rpn_pkg::S_READ: begin
        unique case (op_r)
          rpn_pkg::OP_ADD: top_nxt = rd_data + top_r;
          rpn_pkg::OP_SUB: top_nxt = rd_data - top_r;
          rpn_pkg::OP_MUL: top_nxt = DW'(rd_data * top_r);
          rpn_pkg::OP_DIV: top_nxt = top_r;
          default:         top_nxt = top_r;
        endcase
        if (op_r == rpn_pkg::OP_DIV) begin
          div_start = 1'b1;
          state_nxt = rpn_pkg::S_DIV;
        end else begin
          count_nxt = cnt_m1;
          state_nxt = rpn_pkg::S_IDLE;
        end
      end

      rpn_pkg::S_DIV: begin
        if (div_done) begin
          top_nxt   = quotient;
          count_nxt = cnt_m1;
          state_nxt = rpn_pkg::S_IDLE;
        end
      end

      // load the output register once it is free
      rpn_pkg::S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_st_nxt    = res_st_r;
          state_nxt     = rpn_pkg::S_IDLE;
        end
      end

      default: state_nxt = rpn_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpn_pkg::S_IDLE;
      count_r     <= '0;
      disc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      disc_r      <= disc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r     <= top_nxt;
    op_r      <= op_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
  end

  // result channel
  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_val_r;
  assign out_ch.status = out_st_r;

endmodule

// ===== tb/sv/rpn_stack_evaluator_top_tb.sv =====
`timescale 1ns / 1ps
module rpn_stack_evaluator_top_tb;

  localparam int          STACK_DEPTH = 16;
  localparam int          ITEM_TARGET = 1200;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam logic [30:0] NUM_MAX     = 31'h7FFF_FFFF;

  // one token as queued for the driver; drain marks a pause until results are in
  typedef struct {
    rpn_pkg::req_e_t kind;
    logic [30:0]     num;
    rpn_pkg::op_e_t  op;
    int unsigned     gap;
    bit              drain;
  } token_t;

  typedef struct {
    logic signed [31:0] value;
    rpn_pkg::status_e_t status;
  } calc_result_t;

  logic clk;
  logic rst_n;

  rpn_in_if  in_if ();
  rpn_out_if out_if ();

  rpn_stack_evaluator_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // stimulus and expectation stores
  token_t       token_q[$];
  calc_result_t pending_results[$];

  // shadow calculator state
  logic [31:0] calc_stack [STACK_DEPTH];
  int          calc_depth;
  bit          calc_discard;

  // bookkeeping
  int  cycle_cnt;
  int  err_cnt;
  int  live_tokens;
  int  ignored_tokens;
  int  div_cnt;
  int  results_checked;
  int  drain_cnt;
  int  status_seen [6];
  bit  tx_calm;
  bit  rx_calm;

  // driver and monitor locals
  token_t      cur_tok;
  bit          staged;
  bit          busy;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          rdy;

  // clock, known input levels from time zero
  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.req_type      = rpn_pkg::REQ_PUSH;
    in_if.number_value  = '0;
    in_if.op_code       = rpn_pkg::OP_ADD;
    out_if.ready        = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 30) begin
      $display("tb: mismatch at cycle %0d: %s", cycle_cnt, msg);
    end
  endtask

  // signed division truncating toward zero, most negative / -1 wraps
  function automatic logic [31:0] trunc_div(input logic [31:0] num, input logic [31:0] den);
    logic [31:0] mag_n;
    logic [31:0] mag_d;
    logic [31:0] q;
    mag_n = num[31] ? (32'd0 - num) : num;
    mag_d = den[31] ? (32'd0 - den) : den;
    q     = mag_n / mag_d;
    return (num[31] ^ den[31]) ? (32'd0 - q) : q;
  endfunction

  // append to the stores
  task automatic queue_token(input token_t t);
    token_q = {token_q, t};
  endtask

  task automatic expect_result(input calc_result_t r);
    pending_results = {pending_results, r};
  endtask

  task automatic flag_error(input rpn_pkg::status_e_t st);
    calc_result_t r;
    r.value  = '0;
    r.status = st;
    expect_result(r);
    calc_discard = 1'b1;
  endtask

  // advance the shadow calculator by one accepted token
  task automatic apply_token(input token_t t);
    calc_result_t r;
    logic [31:0]  lhs;
    logic [31:0]  rhs;
    logic [31:0]  res;
    bit           ok;
    if (t.kind == rpn_pkg::REQ_END) begin
      live_tokens++;
      if (!calc_discard) begin
        if (calc_depth == 1) begin
          r.value  = calc_stack[0];
          r.status = rpn_pkg::ST_OK;
        end else begin
          r.value  = '0;
          r.status = rpn_pkg::ST_COUNT;
        end
        expect_result(r);
      end
      calc_depth   = 0;
      calc_discard = 1'b0;
    end else if (calc_discard) begin
      ignored_tokens++;
    end else begin
      live_tokens++;
      case (t.kind)
        rpn_pkg::REQ_PUSH: begin
          if (calc_depth >= STACK_DEPTH) begin
            flag_error(rpn_pkg::ST_OVERFLOW);
          end else begin
            calc_stack[calc_depth] = {1'b0, t.num};
            calc_depth++;
          end
        end
        rpn_pkg::REQ_OP: begin
          if (calc_depth < 2) begin
            flag_error(rpn_pkg::ST_FEW);
          end else begin
            lhs = calc_stack[calc_depth-2];
            rhs = calc_stack[calc_depth-1];
            ok  = 1'b1;
            res = '0;
            case (t.op)
              rpn_pkg::OP_ADD: res = lhs + rhs;
              rpn_pkg::OP_SUB: res = lhs - rhs;
              rpn_pkg::OP_MUL: res = lhs * rhs;
              default: begin
                if (rhs == 32'd0) begin
                  flag_error(rpn_pkg::ST_DIVZERO);
                  ok = 1'b0;
                end else begin
                  res = trunc_div(lhs, rhs);
                  div_cnt++;
                end
              end
            endcase
            if (ok) begin
              calc_depth--;
              calc_stack[calc_depth-1] = res;
            end
          end
        end
        default: flag_error(rpn_pkg::ST_INVALID);
      endcase
    end
  endtask

  // token queueing
  function automatic int unsigned draw_gap();
    return tx_calm ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic add_push(input logic [30:0] n);
    token_t t;
    t.kind  = rpn_pkg::REQ_PUSH;
    t.num   = n;
    t.op    = rpn_pkg::op_e_t'($urandom_range(0, 3));
    t.gap   = draw_gap();
    t.drain = 1'b0;
    queue_token(t);
  endtask

  task automatic add_op(input rpn_pkg::op_e_t o);
    token_t t;
    t.kind  = rpn_pkg::REQ_OP;
    t.num   = 31'($urandom());
    t.op    = o;
    t.gap   = draw_gap();
    t.drain = 1'b0;
    queue_token(t);
  endtask

  task automatic add_ctl(input rpn_pkg::req_e_t k);
    token_t t;
    t.kind  = k;
    t.num   = 31'($urandom());
    t.op    = rpn_pkg::op_e_t'($urandom_range(0, 3));
    t.gap   = draw_gap();
    t.drain = 1'b0;
    queue_token(t);
  endtask

  task automatic add_drain();
    token_t t;
    t.kind  = rpn_pkg::REQ_END;
    t.num   = '0;
    t.op    = rpn_pkg::OP_ADD;
    t.gap   = 0;
    t.drain = 1'b1;
    queue_token(t);
  endtask

  // operand values weighted toward zero, small values and the extremes
  function automatic logic [30:0] rand_number();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return NUM_MAX;
      2, 3:    return 31'($urandom_range(0, 15));
      4:       return 31'($urandom_range(0, 65535));
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic rpn_pkg::op_e_t rand_op();
    return rpn_pkg::op_e_t'($urandom_range(0, 3));
  endfunction

  // one expression, mostly well formed, sometimes broken on purpose
  task automatic gen_expression();
    int shape;
    int leaves;
    int depth;
    int n;
    shape   = $urandom_range(0, 19);
    tx_calm = ($urandom_range(0, 3) == 0);
    depth   = 0;
    if (shape < 13) begin
      // well formed expression with random interleaving of pushes and operators
      leaves = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 9);
      while (leaves > 0 || depth > 1) begin
        if (depth < 2 || (leaves > 0 && $urandom_range(0, 1) == 1)) begin
          add_push(rand_number());
          depth++;
          leaves--;
        end else begin
          add_op(rand_op());
          depth--;
        end
      end
      add_ctl(rpn_pkg::REQ_END);
    end else if (shape == 13) begin
      // fill the stack completely, then fold it back down
      for (int i = 0; i < STACK_DEPTH; i++) add_push(rand_number());
      for (int i = 1; i < STACK_DEPTH; i++) add_op(rand_op());
      add_ctl(rpn_pkg::REQ_END);
    end else if (shape == 14) begin
      // push past the top of the stack, trailing tokens are dropped
      n = STACK_DEPTH + $urandom_range(1, 3);
      for (int i = 0; i < n; i++) add_push(rand_number());
      if ($urandom_range(0, 1) == 1) add_op(rand_op());
      add_ctl(rpn_pkg::REQ_END);
    end else if (shape == 15) begin
      // wrong number of entries left at the end
      n = $urandom_range(0, 4);
      if (n == 1) n = 0;
      for (int i = 0; i < n; i++) add_push(rand_number());
      if (n > 2 && $urandom_range(0, 1) == 1) add_op(rand_op());
      add_ctl(rpn_pkg::REQ_END);
    end else if (shape == 16) begin
      // operator with too few operands
      n = $urandom_range(0, 1);
      for (int i = 0; i < n; i++) add_push(rand_number());
      add_op(rand_op());
      add_push(rand_number());
      add_ctl(rpn_pkg::REQ_END);
    end else if (shape == 17) begin
      // bad token inside an otherwise good expression
      add_push(rand_number());
      add_push(rand_number());
      add_ctl(rpn_pkg::REQ_INVALID);
      add_op(rand_op());
      add_ctl(rpn_pkg::REQ_END);
    end else if (shape == 18) begin
      // division with a zero divisor
      add_push(rand_number());
      add_push('0);
      add_op(rpn_pkg::OP_DIV);
      add_push(rand_number());
      add_ctl(rpn_pkg::REQ_END);
    end else begin
      // noise: fully random tokens
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0: add_push(rand_number());
          1: add_op(rand_op());
          2: add_ctl(rpn_pkg::REQ_END);
          default: add_ctl(rpn_pkg::REQ_INVALID);
        endcase
      end
      add_ctl(rpn_pkg::REQ_END);
    end
  endtask

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      staged     = 1'b0;
      gap_left   = 0;
    end else begin
      busy = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        apply_token(cur_tok);
        busy = 1'b0;
      end
      if (!busy) begin
        // a drain marker holds the sender until all results are back
        if (!staged && token_q.size() > 0 && token_q[0].drain) begin
          if (pending_results.size() == 0) begin
            void'(token_q.pop_front());
            drain_cnt++;
          end
        end else if (!staged && token_q.size() > 0) begin
          cur_tok  = token_q.pop_front();
          gap_left = cur_tok.gap;
          staged   = 1'b1;
        end
        if (staged) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            in_if.req_type     <= cur_tok.kind;
            in_if.number_value <= cur_tok.num;
            in_if.op_code      <= cur_tok.op;
            staged = 1'b0;
            busy   = 1'b1;
          end
        end
      end
      in_if.valid <= busy;
    end
  end

  // result monitor and backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
      rx_calm    = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction value %0d status %0d",
                                    out_if.value, out_if.status));
        end else begin
          if (out_if.status <= rpn_pkg::ST_DIVZERO) status_seen[out_if.status]++;
          if (out_if.value !== pending_results[0].value) begin
            report_mismatch($sformatf("value %0d, expected %0d",
                                      out_if.value, pending_results[0].value));
          end
          if (out_if.status !== pending_results[0].status) begin
            report_mismatch($sformatf("status %0d, expected %s",
                                      out_if.status, pending_results[0].status.name()));
          end
          void'(pending_results.pop_front());
        end
        if ($urandom_range(0, 29) == 0) rx_calm = ~rx_calm;
        stall_left = rx_calm ? 0 : $urandom_range(0, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_if.ready <= rdy;
    end
  end

  // stimulus sequence and end of run
  initial begin
    int expr_cnt;
    expr_cnt = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // most negative value over minus one, subtract, extremes
    add_push('0);
    add_push(NUM_MAX);
    add_op(rpn_pkg::OP_SUB);
    add_push(31'd1);
    add_op(rpn_pkg::OP_SUB);
    add_push('0);
    add_push(31'd1);
    add_op(rpn_pkg::OP_SUB);
    add_op(rpn_pkg::OP_DIV);
    add_ctl(rpn_pkg::REQ_END);
    // wrapping multiply and add
    add_push(31'd3);
    add_push(NUM_MAX);
    add_push(NUM_MAX);
    add_op(rpn_pkg::OP_MUL);
    add_op(rpn_pkg::OP_ADD);
    add_ctl(rpn_pkg::REQ_END);
    // divide by zero, following push is dropped
    add_push(31'd9);
    add_push('0);
    add_op(rpn_pkg::OP_DIV);
    add_push(31'd4);
    add_ctl(rpn_pkg::REQ_END);
    // operator on an empty stack
    add_op(rpn_pkg::OP_ADD);
    add_ctl(rpn_pkg::REQ_END);
    // invalid token
    add_ctl(rpn_pkg::REQ_INVALID);
    add_ctl(rpn_pkg::REQ_END);
    // end marker on an empty stack
    add_ctl(rpn_pkg::REQ_END);
    add_drain();

    // random expressions, with a full drain now and then
    while (live_tokens < ITEM_TARGET) begin
      if (token_q.size() < 16) begin
        gen_expression();
        expr_cnt++;
        if (expr_cnt % 150 == 0) add_drain();
      end else begin
        @(posedge clk);
      end
    end

    while (token_q.size() > 0 || staged || in_if.valid) @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("run covered %0d tokens (%0d dropped while discarding), %0d divisions, %0d drains",
             live_tokens + ignored_tokens, ignored_tokens, div_cnt, drain_cnt);
    $display("%0d results: ok %0d, few %0d, invalid %0d, count %0d, overflow %0d, div0 %0d",
             results_checked, status_seen[rpn_pkg::ST_OK], status_seen[rpn_pkg::ST_FEW],
             status_seen[rpn_pkg::ST_INVALID], status_seen[rpn_pkg::ST_COUNT],
             status_seen[rpn_pkg::ST_OVERFLOW], status_seen[rpn_pkg::ST_DIVZERO]);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
